@@ sv/gpa_pkg.sv @@
// Shared types, constants and command/status structs for the GBM path payoff block.
// No dependencies; imported by every module of the block.
package gpa_pkg;

	// default fixed-point formats
	localparam int PRICE_FRAC_BITS_DEF = 24;
	localparam int DRAW_FRAC_BITS_DEF  = 20;
	localparam int SUM_WIDTH_DEF       = 64;
	localparam int COEF_FRAC           = 32;

	// register reset values
	localparam logic [46:0] SPOT_RESET = 47'd1677721600;
	localparam logic [32:0] DISC_RESET = 33'h1_0000_0000;

	// mode bit positions
	localparam int MODE_MILSTEIN = 0;
	localparam int MODE_PUT      = 1;
	localparam int MODE_ANTI     = 2;

	typedef enum logic [2:0] {
		CFG_SPOT   = 3'd0,
		CFG_DRIFT  = 3'd1,
		CFG_SQRTDT = 3'd2,
		CFG_VOL    = 3'd3,
		CFG_DT     = 3'd4,
		CFG_STRIKE = 3'd5,
		CFG_DISC   = 3'd6,
		CFG_MODE   = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic signed [23:0] normal_draw;
		logic               path_end;
		logic               run_start;
	} in_t;

	typedef struct packed {
		logic [46:0] path_value;
		logic [46:0] control_value;
		logic [31:0] path_count;
		logic [63:0] sum_value;
		logic [63:0] sum_value_squared;
		logic [63:0] sum_control;
		logic [63:0] sum_control_squared;
		logic [63:0] sum_cross;
		logic        saturated;
	} out_t;

	// one product on the shared multiplier
	typedef enum logic [3:0] {
		OP_DW, OP_VDW, OP_DW2, OP_SIG2, OP_MIL, OP_DS_UP, OP_DS_DN,
		OP_Y, OP_C, OP_YY, OP_CC, OP_YC
	} op_t;

	typedef enum logic [1:0] {SH_DRAW, SH_COEF, SH_COEF1, SH_PRICE} sh_t;
	typedef enum logic [1:0] {CAP_MID, CAP_DS, CAP_OUT, CAP_ALL} cap_t;

	typedef struct packed {
		logic accept;
		logic start;
		op_t  op;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic mul_done;
		logic milstein;
		logic path_end;
		logic out_free;
	} sts_t;

endpackage

@@ sv/gbm_path_payoff_accumulator_core.sv @@
// Top level of the GBM path payoff accumulator: controller plus datapath.
// Depends on gpa_pkg, gpa_ctrl, gpa_dp (and gpa_mul below it).
//
// Usage:
//  Input channel (in_valid/in_ready/in_item) takes one normal draw per item,
//  with path_end marking the last step of a path and run_start clearing the
//  sums and path count first. Output channel (out_valid/out_ready/out_item)
//  gives one item per path end: discounted payoff, discounted control price,
//  path count and the five saturating moment sums.
//  Configuration is written through cfg_wr_en/cfg_index/cfg_wr_data while idle.
//  Sequencing: every product goes through one 32x32 multiplier in four partial
//  products plus a shift/cap step. An Euler step takes 4 products, a Milstein
//  step 7; a path end adds 5 more products and a write into the output
//  register. One item is in work at a time.
//  Reset: registers take their reset values, sums and count clear, and the
//  first item starts a fresh path from spot_price.
//  Stall: a finished result waits in the output register; the next item is
//  still taken, and only a following path end waits for the register to free.
module gbm_path_payoff_accumulator_core #(
	parameter int PRICE_FRAC_BITS = gpa_pkg::PRICE_FRAC_BITS_DEF,
	parameter int DRAW_FRAC_BITS  = gpa_pkg::DRAW_FRAC_BITS_DEF,
	parameter int SUM_WIDTH       = gpa_pkg::SUM_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wr_en,
	input  logic [2:0]    cfg_index,
	input  logic [46:0]   cfg_wr_data,
	input  logic          in_valid,
	output logic          in_ready,
	input  gpa_pkg::in_t  in_item,
	output logic          out_valid,
	input  logic          out_ready,
	output gpa_pkg::out_t out_item
);
	import gpa_pkg::*;

	cmd_t cmd;
	sts_t sts;

	gpa_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	gpa_dp #(
		.PRICE_FRAC_BITS(PRICE_FRAC_BITS),
		.DRAW_FRAC_BITS (DRAW_FRAC_BITS),
		.SUM_WIDTH      (SUM_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_wr_data(cfg_wr_data),
		.in_item    (in_item),
		.out_item   (out_item),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.cmd        (cmd),
		.sts        (sts)
	);

endmodule

@@ sv/gpa_mul.sv @@
// Multi-cycle 64x64 product with shift and cap, built on one 32x32 multiplier.
// Depends on gpa_pkg.
module gpa_mul #(
	parameter int PRICE_FRAC_BITS = gpa_pkg::PRICE_FRAC_BITS_DEF,
	parameter int DRAW_FRAC_BITS  = gpa_pkg::DRAW_FRAC_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [63:0]   a,
	input  logic [63:0]   b,
	input  gpa_pkg::sh_t  sh,
	input  gpa_pkg::cap_t cap,
	output logic          done,
	output logic [63:0]   res
);
	import gpa_pkg::*;

	logic [63:0]  a_q, b_q;
	sh_t          sh_q;
	cap_t         cap_q;
	logic [2:0]   cnt_q;
	logic         busy_q;
	logic         done_q;
	logic [63:0]  pp_q;
	logic [1:0]   pidx_q;
	logic [127:0] acc_q;
	logic [63:0]  res_q;

	logic [31:0]  a_half, b_half;
	logic [127:0] pp_ext, shifted;
	logic [63:0]  cap_val, res_next;

	// partial product select and alignment
	always_comb begin
		a_half = cnt_q[0] ? a_q[63:32] : a_q[31:0];
		b_half = cnt_q[1] ? b_q[63:32] : b_q[31:0];
		case (pidx_q)
			2'd0:    pp_ext = {64'd0, pp_q};
			2'd3:    pp_ext = {pp_q, 64'd0};
			default: pp_ext = {32'd0, pp_q, 32'd0};
		endcase
	end

	// final shift and cap
	always_comb begin
		case (sh_q)
			SH_DRAW:  shifted = acc_q >> DRAW_FRAC_BITS;
			SH_COEF:  shifted = acc_q >> COEF_FRAC;
			SH_COEF1: shifted = acc_q >> (COEF_FRAC + 1);
			SH_PRICE: shifted = acc_q >> PRICE_FRAC_BITS;
			default:  shifted = acc_q;
		endcase
		case (cap_q)
			CAP_MID: cap_val = 64'd1 << 60;
			CAP_DS:  cap_val = 64'd1 << 62;
			CAP_OUT: cap_val = (64'd1 << 47) - 64'd1;
			default: cap_val = '1;
		endcase
		res_next = ((|shifted[127:64]) || (shifted[63:0] > cap_val)) ? cap_val
			: shifted[63:0];
	end

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd5) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// operands, partial products and accumulation
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			sh_q  <= sh;
			cap_q <= cap;
			acc_q <= '0;
		end else if (busy_q) begin
			if (cnt_q < 3'd4) begin
				pp_q   <= a_half * b_half;
				pidx_q <= cnt_q[1:0];
			end
			if (cnt_q >= 3'd1 && cnt_q <= 3'd4)
				acc_q <= acc_q + pp_ext;
			if (cnt_q == 3'd5)
				res_q <= res_next;
		end
	end

	assign done = done_q;
	assign res  = res_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("multiplier restarted while busy");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("done while still busy");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q)) else $error("done without a product in flight");

endmodule

@@ sv/gpa_dp.sv @@
// Datapath: configuration registers, lane prices, moment sums, output register.
// Depends on gpa_pkg and gpa_mul.
module gpa_dp #(
	parameter int PRICE_FRAC_BITS = gpa_pkg::PRICE_FRAC_BITS_DEF,
	parameter int DRAW_FRAC_BITS  = gpa_pkg::DRAW_FRAC_BITS_DEF,
	parameter int SUM_WIDTH       = gpa_pkg::SUM_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wr_en,
	input  logic [2:0]    cfg_index,
	input  logic [46:0]   cfg_wr_data,
	input  gpa_pkg::in_t  in_item,
	output gpa_pkg::out_t out_item,
	output logic          out_valid,
	input  logic          out_ready,
	input  gpa_pkg::cmd_t cmd,
	output gpa_pkg::sts_t sts
);
	import gpa_pkg::*;

	localparam logic [SUM_WIDTH-1:0] SUM_MAX = '1;
	localparam logic [47:0] PRICE_MAX = '1;

	// configuration
	logic [46:0]        spot_q, strike_q;
	logic signed [39:0] drift_q;
	logic [31:0]        sqrtdt_q, dt_q;
	logic [35:0]        vol_q;
	logic [32:0]        disc_q;
	logic [2:0]         mode_q;

	// item and step state
	logic               pe_q;
	logic               dw_neg_q;
	logic [60:0]        dw_mag_q, vdw_mag_q, dw2_q, sig2_q;
	logic [61:0]        mil_q;
	logic [47:0]        price_up_q, price_dn_q;
	logic [46:0]        y_q, c_q;
	logic               at_start_q;
	logic [31:0]        paths_q;
	logic [SUM_WIDTH-1:0] acc_v_q, acc_vsq_q, acc_c_q, acc_csq_q, acc_x_q;
	logic               sat_q;
	op_t                wb_op_q;
	out_t               out_q;
	logic               out_valid_q;

	logic [63:0] mul_a, mul_b, mul_res;
	sh_t         mul_sh;
	cap_t        mul_cap;
	logic        mul_done;

	logic [23:0] z_mag;
	logic [63:0] drift_s, vdw_s, mil_s, f_up, f_dn, f_up_mag, f_dn_mag;
	logic [61:0] d_s, d_mag;
	logic [47:0] pay_up, pay_dn;
	logic [48:0] pay_sum, price_sum;
	logic        anti;
	logic [31:0] paths_next;

	function automatic logic [47:0] lane_next(input logic [47:0] s,
		input logic [62:0] ds, input logic neg);
		logic [62:0] sum;
		logic [47:0] r;
		sum = 63'(s) + ds;
		if (!neg)
			r = (sum > 63'(PRICE_MAX)) ? PRICE_MAX : sum[47:0];
		else
			r = (ds >= 63'(s)) ? 48'd0 : s - ds[47:0];
		return (r == 48'd0) ? 48'd1 : r;
	endfunction

	function automatic logic [47:0] payoff(input logic [47:0] s, input logic put,
		input logic [46:0] k);
		if (put)
			return (48'(k) > s) ? 48'(k) - s : 48'd0;
		return (s > 48'(k)) ? s - 48'(k) : 48'd0;
	endfunction

	// saturating add, flag in the top bit
	function automatic logic [SUM_WIDTH:0] add_sat(input logic [SUM_WIDTH-1:0] acc,
		input logic [63:0] t);
		logic [64:0] s;
		s = 65'(acc) + {1'b0, t};
		if (s > 65'(SUM_MAX))
			return {1'b1, SUM_MAX};
		return {1'b0, s[SUM_WIDTH-1:0]};
	endfunction

	// step coefficients; the draw magnitude is taken straight from the item being accepted
	always_comb begin
		z_mag    = in_item.normal_draw[23] ? (~in_item.normal_draw + 24'd1)
			: in_item.normal_draw;
		drift_s  = {{24{drift_q[39]}}, drift_q};
		vdw_s    = dw_neg_q ? (64'd0 - {3'd0, vdw_mag_q}) : {3'd0, vdw_mag_q};
		mil_s    = {{2{mil_q[61]}}, mil_q};
		f_up     = drift_s + vdw_s + mil_s;
		f_dn     = drift_s - vdw_s + mil_s;
		f_up_mag = f_up[63] ? (64'd0 - f_up) : f_up;
		f_dn_mag = f_dn[63] ? (64'd0 - f_dn) : f_dn;
		d_s      = 62'(dw2_q) - 62'(dt_q);
		d_mag    = d_s[61] ? (62'd0 - d_s) : d_s;
		anti      = mode_q[MODE_ANTI];
		pay_up    = payoff(price_up_q, mode_q[MODE_PUT], strike_q);
		pay_dn    = payoff(price_dn_q, mode_q[MODE_PUT], strike_q);
		pay_sum   = 49'(pay_up) + 49'(pay_dn);
		price_sum = 49'(price_up_q) + 49'(price_dn_q);
		paths_next = (&paths_q) ? paths_q : paths_q + 32'd1;
	end

	// multiplier operand select
	always_comb begin
		mul_a   = '0;
		mul_b   = '0;
		mul_sh  = SH_COEF;
		mul_cap = CAP_MID;
		case (cmd.op)
			OP_DW: begin
				mul_a  = 64'(z_mag);
				mul_b  = 64'(sqrtdt_q);
				mul_sh = SH_DRAW;
			end
			OP_VDW: begin
				mul_a = 64'(dw_mag_q);
				mul_b = 64'(vol_q);
			end
			OP_DW2: begin
				mul_a = 64'(dw_mag_q);
				mul_b = 64'(dw_mag_q);
			end
			OP_SIG2: begin
				mul_a = 64'(vol_q);
				mul_b = 64'(vol_q);
			end
			OP_MIL: begin
				mul_a  = 64'(d_mag);
				mul_b  = 64'(sig2_q);
				mul_sh = SH_COEF1;
			end
			OP_DS_UP: begin
				mul_a   = 64'(price_up_q);
				mul_b   = f_up_mag;
				mul_cap = CAP_DS;
			end
			OP_DS_DN: begin
				mul_a   = 64'(price_dn_q);
				mul_b   = f_dn_mag;
				mul_cap = CAP_DS;
			end
			OP_Y: begin
				mul_a   = anti ? 64'(pay_sum) : 64'(pay_up);
				mul_b   = 64'(disc_q);
				mul_sh  = anti ? SH_COEF1 : SH_COEF;
				mul_cap = CAP_OUT;
			end
			OP_C: begin
				mul_a   = anti ? 64'(price_sum) : 64'(price_up_q);
				mul_b   = 64'(disc_q);
				mul_sh  = anti ? SH_COEF1 : SH_COEF;
				mul_cap = CAP_OUT;
			end
			OP_YY: begin
				mul_a   = 64'(y_q);
				mul_b   = 64'(y_q);
				mul_sh  = SH_PRICE;
				mul_cap = CAP_ALL;
			end
			OP_CC: begin
				mul_a   = 64'(c_q);
				mul_b   = 64'(c_q);
				mul_sh  = SH_PRICE;
				mul_cap = CAP_ALL;
			end
			OP_YC: begin
				mul_a   = 64'(y_q);
				mul_b   = 64'(c_q);
				mul_sh  = SH_PRICE;
				mul_cap = CAP_ALL;
			end
			default: ;
		endcase
	end

	gpa_mul #(
		.PRICE_FRAC_BITS(PRICE_FRAC_BITS),
		.DRAW_FRAC_BITS (DRAW_FRAC_BITS)
	) u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.start),
		.a     (mul_a),
		.b     (mul_b),
		.sh    (mul_sh),
		.cap   (mul_cap),
		.done  (mul_done),
		.res   (mul_res)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spot_q   <= SPOT_RESET;
			drift_q  <= '0;
			sqrtdt_q <= '0;
			vol_q    <= '0;
			dt_q     <= '0;
			strike_q <= '0;
			disc_q   <= DISC_RESET;
			mode_q   <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_idx_t'(cfg_index))
				CFG_SPOT:   spot_q   <= cfg_wr_data;
				CFG_DRIFT:  drift_q  <= cfg_wr_data[39:0];
				CFG_SQRTDT: sqrtdt_q <= cfg_wr_data[31:0];
				CFG_VOL:    vol_q    <= cfg_wr_data[35:0];
				CFG_DT:     dt_q     <= cfg_wr_data[31:0];
				CFG_STRIKE: strike_q <= cfg_wr_data;
				CFG_DISC:   disc_q   <= cfg_wr_data[32:0];
				CFG_MODE:   mode_q   <= cfg_wr_data[2:0];
				default: ;
			endcase
		end
	end

	// run state: path start flag, count, sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_start_q  <= 1'b1;
			paths_q     <= '0;
			acc_v_q     <= '0;
			acc_vsq_q   <= '0;
			acc_c_q     <= '0;
			acc_csq_q   <= '0;
			acc_x_q     <= '0;
			sat_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			if (cmd.accept) begin
				at_start_q <= 1'b0;
				if (in_item.run_start) begin
					paths_q   <= '0;
					acc_v_q   <= '0;
					acc_vsq_q <= '0;
					acc_c_q   <= '0;
					acc_csq_q <= '0;
					acc_x_q   <= '0;
					sat_q     <= 1'b0;
				end
			end else if (cmd.emit) begin
				at_start_q <= 1'b1;
				paths_q    <= paths_next;
			end else if (mul_done) begin
				case (wb_op_q)
					OP_Y: begin
						{sat_q, acc_v_q} <= add_sat(acc_v_q, 64'(mul_res[46:0])) |
							{sat_q, {SUM_WIDTH{1'b0}}};
					end
					OP_C: begin
						{sat_q, acc_c_q} <= add_sat(acc_c_q, 64'(mul_res[46:0])) |
							{sat_q, {SUM_WIDTH{1'b0}}};
					end
					OP_YY: begin
						{sat_q, acc_vsq_q} <= add_sat(acc_vsq_q, mul_res) |
							{sat_q, {SUM_WIDTH{1'b0}}};
					end
					OP_CC: begin
						{sat_q, acc_csq_q} <= add_sat(acc_csq_q, mul_res) |
							{sat_q, {SUM_WIDTH{1'b0}}};
					end
					OP_YC: begin
						{sat_q, acc_x_q} <= add_sat(acc_x_q, mul_res) |
							{sat_q, {SUM_WIDTH{1'b0}}};
					end
					default: ;
				endcase
			end
		end
	end

	// item payload, lane prices and intermediate products
	always_ff @(posedge clk) begin
		if (cmd.start)
			wb_op_q <= cmd.op;
		if (cmd.accept) begin
			pe_q     <= in_item.path_end;
			dw_neg_q <= in_item.normal_draw[23];
			mil_q    <= '0;
			if (in_item.run_start || at_start_q) begin
				price_up_q <= 48'(spot_q);
				price_dn_q <= 48'(spot_q);
			end
		end else if (mul_done) begin
			case (wb_op_q)
				OP_DW:    dw_mag_q   <= mul_res[60:0];
				OP_VDW:   vdw_mag_q  <= mul_res[60:0];
				OP_DW2:   dw2_q      <= mul_res[60:0];
				OP_SIG2:  sig2_q     <= mul_res[60:0];
				OP_MIL:   mil_q      <= d_s[61] ? (62'd0 - 62'(mul_res[60:0]))
					: 62'(mul_res[60:0]);
				OP_DS_UP: price_up_q <= lane_next(price_up_q, mul_res[62:0], f_up[63]);
				OP_DS_DN: price_dn_q <= lane_next(price_dn_q, mul_res[62:0], f_dn[63]);
				OP_Y:     y_q        <= mul_res[46:0];
				OP_C:     c_q        <= mul_res[46:0];
				default: ;
			endcase
		end
		if (cmd.emit) begin
			out_q.path_value          <= y_q;
			out_q.control_value       <= c_q;
			out_q.path_count          <= paths_next;
			out_q.sum_value           <= 64'(acc_v_q);
			out_q.sum_value_squared   <= 64'(acc_vsq_q);
			out_q.sum_control         <= 64'(acc_c_q);
			out_q.sum_control_squared <= 64'(acc_csq_q);
			out_q.sum_cross           <= 64'(acc_x_q);
			out_q.saturated           <= sat_q;
		end
	end

	assign out_item = out_q;
	assign out_valid = out_valid_q;

	assign sts.mul_done = mul_done;
	assign sts.milstein = mode_q[MODE_MILSTEIN];
	assign sts.path_end = pe_q;
	assign sts.out_free = !out_valid_q || out_ready;

endmodule

@@ sv/gpa_ctrl.sv @@
// Controller: sequences the products of one step and the path end on the shared multiplier.
// Depends on gpa_pkg.
module gpa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  gpa_pkg::sts_t sts,
	output gpa_pkg::cmd_t cmd
);
	import gpa_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_BUSY, S_EMIT} state_t;

	state_t state_q;
	op_t    op_q;
	op_t    op_next;

	// product order: dW, sigma*dW, Milstein terms, both lanes, then path end
	always_comb begin
		case (op_q)
			OP_DW:    op_next = OP_VDW;
			OP_VDW:   op_next = sts.milstein ? OP_DW2 : OP_DS_UP;
			OP_DW2:   op_next = OP_SIG2;
			OP_SIG2:  op_next = OP_MIL;
			OP_MIL:   op_next = OP_DS_UP;
			OP_DS_UP: op_next = OP_DS_DN;
			OP_DS_DN: op_next = OP_Y;
			OP_Y:     op_next = OP_C;
			OP_C:     op_next = OP_YY;
			OP_YY:    op_next = OP_CC;
			OP_CC:    op_next = OP_YC;
			default:  op_next = OP_DW;
		endcase
	end

	always_comb begin
		in_ready   = (state_q == S_IDLE);
		cmd.accept = (state_q == S_IDLE) && in_valid;
		cmd.start  = cmd.accept || (state_q == S_ISSUE);
		cmd.op     = (state_q == S_IDLE) ? OP_DW : op_q;
		cmd.emit   = (state_q == S_EMIT) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_DW;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q    <= OP_DW;
						state_q <= S_BUSY;
					end
				end
				S_ISSUE: state_q <= S_BUSY;
				S_BUSY: begin
					if (sts.mul_done) begin
						if (op_q == OP_DS_DN && !sts.path_end)
							state_q <= S_IDLE;
						else if (op_q == OP_YC)
							state_q <= S_EMIT;
						else begin
							op_q    <= op_next;
							state_q <= S_ISSUE;
						end
					end
				end
				S_EMIT: begin
					if (sts.out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_done_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sts.mul_done |-> state_q == S_BUSY) else $error("product done outside busy");
	a_emit_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> state_q == S_IDLE) else $error("emit did not finish the item");
	a_tail_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BUSY && op_q == OP_YC) |-> sts.path_end)
		else $error("payoff products on a non-final step");

endmodule
